/* src/dictionary_encoder_linear_probe_macros.svh */
// Assertion macros shared by the dictionary encoder RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef DICTIONARY_ENCODER_LINEAR_PROBE_MACROS_SVH
`define DICTIONARY_ENCODER_LINEAR_PROBE_MACROS_SVH

// Same-cycle implication, checked on i_clk and disabled while in reset.
`define DEP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and disabled while in reset.
`define DEP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dep_pkg.sv */
// Package for the dictionary encoder: field widths, slot record, sequencer states.
// No dependencies; imported by all other files but the assertion macro header.
package dep_pkg;

    localparam int VALUE_W  = 64;
    localparam int CODE_W   = 10;
    localparam int COUNT_W  = 11;
    localparam int TSIZE_W  = 11;
    localparam int BYTES_W  = 4;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 11;

    localparam logic [CFG_AW-1:0] REG_TABLE_SIZE   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_VALUE_BYTES  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_STORED_BYTES = 2'd2;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic               used;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] key;
    } t_slot;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic               null_row;
        logic               new_entry;
        logic [VALUE_W-1:0] dict_word;
        logic [COUNT_W-1:0] distinct_count;
        logic               overflow;
    } t_result;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } t_state;

    // Keeps the low nbytes bytes; zero counts as one, counts above eight keep all.
    function automatic logic [VALUE_W-1:0] byte_mask(input logic [BYTES_W-1:0] nbytes);
        logic [VALUE_W-1:0] m;
        logic [BYTES_W-1:0] n;
        n = (nbytes == '0) ? BYTES_W'(1) : nbytes;
        for (int i = 0; i < VALUE_W / 8; i++) begin
            m[i*8 +: 8] = (BYTES_W'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

/* src/dep_if.sv */
// Handshake interfaces for the dictionary encoder: input rows, results, config writes.
// Depends on dep_pkg for field widths.
interface dep_in_if;
    import dep_pkg::*;
    logic               valid;
    logic               ready;
    logic               op;
    logic [VALUE_W-1:0] row_value;
    logic               row_is_null;
    modport source (output valid, op, row_value, row_is_null, input ready);
    modport sink   (input valid, op, row_value, row_is_null, output ready);
endinterface

interface dep_out_if;
    import dep_pkg::*;
    logic               valid;
    logic               ready;
    logic [CODE_W-1:0]  code;
    logic               null_row;
    logic               new_entry;
    logic [VALUE_W-1:0] dict_word;
    logic [COUNT_W-1:0] distinct_count;
    logic               overflow;
    modport source (output valid, code, null_row, new_entry, dict_word, distinct_count,
                    overflow, input ready);
    modport sink   (input valid, code, null_row, new_entry, dict_word, distinct_count,
                    overflow, output ready);
endinterface

interface dep_cfg_if;
    import dep_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

/* src/dictionary_encoder_linear_probe.sv */
// Column dictionary encoder with a linear-probing hash table; top level.
// Depends on dep_pkg, dep_if, dep_mod_unit, dep_table and the assertion macro header.
//
// Each encode transaction takes a row value, keeps its low value_bytes bytes and finds
// its home slot as value modulo the table size, computed by a bit-serial remainder unit.
// Slots are then probed one at a time from a slot memory with one write and one read
// port, each probe a read state and then a compare state that may write, wrapping at
// the table size for at most one lap. A null row goes straight to the result without
// probing. An empty slot receives the next dense code and the result carries the
// dictionary word; a matching slot returns its stored code; a full lap sets overflow.
// A clear transaction and reset both sweep all TABLE_DEPTH slots of the slot memory,
// one slot per cycle, during which no input transaction is taken (configuration
// writes are always taken). The result sits in an output register, so a result may wait
// for the consumer while the block is already back in idle.
`include "dictionary_encoder_linear_probe_macros.svh"

module dictionary_encoder_linear_probe #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dep_in_if.sink    i_in,
    dep_out_if.source o_out,
    dep_cfg_if.sink   i_cfg
);
    import dep_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW = (AW + 1 > TSIZE_W) ? AW + 1 : TSIZE_W;

    t_state             r_state, n_state;
    logic [TSIZE_W-1:0] r_table_size;
    logic [BYTES_W-1:0] r_value_bytes, r_stored_bytes;
    logic [COUNT_W-1:0] r_next_code, n_next_code;
    logic [SW-1:0]      r_ts, n_ts;
    logic [SW-1:0]      r_steps, n_steps;
    logic [AW-1:0]      r_pos, n_pos;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic               r_emit, n_emit;
    logic [VALUE_W-1:0] r_key, n_key;
    t_result            r_res, n_res;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               accept;
    logic [SW-1:0]      ts_now;
    logic [SW-1:0]      size_ext;
    logic [VALUE_W-1:0] key_now;
    logic               mod_start, mod_done;
    logic [SW-1:0]      mod_rem;
    logic [SW-1:0]      pos_inc;
    logic               tbl_we, tbl_re;
    logic [AW-1:0]      tbl_waddr;
    t_slot              tbl_wdata, tbl_rdata;

    // Configuration registers; writes are always accepted.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size   <= TSIZE_W'(1024);
            r_value_bytes  <= BYTES_W'(8);
            r_stored_bytes <= BYTES_W'(8);
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                REG_TABLE_SIZE:   r_table_size   <= i_cfg.data[TSIZE_W-1:0];
                REG_VALUE_BYTES:  r_value_bytes  <= i_cfg.data[BYTES_W-1:0];
                REG_STORED_BYTES: r_stored_bytes <= i_cfg.data[BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // The table size in use: zero acts as one, sizes above the memory depth clamp to it.
    assign size_ext = SW'(r_table_size);
    always_comb begin
        if (size_ext == '0) begin
            ts_now = SW'(1);
        end else if (size_ext > SW'(TABLE_DEPTH)) begin
            ts_now = SW'(TABLE_DEPTH);
        end else begin
            ts_now = size_ext;
        end
    end

    assign key_now   = i_in.row_value & byte_mask(r_value_bytes);
    assign accept    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign pos_inc   = SW'(r_pos) + SW'(1);

    dep_mod_unit #(.SW(SW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (key_now),
        .i_divisor  (ts_now),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    dep_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (r_pos),
        .o_rdata (tbl_rdata)
    );

    // Sequencer: next state, datapath updates and memory controls.
    always_comb begin
        n_state     = r_state;
        n_next_code = r_next_code;
        n_ts        = r_ts;
        n_steps     = r_steps;
        n_pos       = r_pos;
        n_clr_addr  = r_clr_addr;
        n_emit      = r_emit;
        n_key       = r_key;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        mod_start   = 1'b0;
        tbl_we      = 1'b0;
        tbl_re      = 1'b0;
        tbl_waddr   = r_pos;
        tbl_wdata   = '{used: 1'b1, code: r_next_code[CODE_W-1:0], key: r_key};

        case (r_state)
            ST_SWEEP: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_clr_addr;
                tbl_wdata = '0;
                if (r_clr_addr == AW'(TABLE_DEPTH - 1)) begin
                    n_clr_addr = '0;
                    n_state    = r_emit ? ST_FINISH : ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    if (i_in.op == OP_CLEAR) begin
                        n_next_code = '0;
                        n_clr_addr  = '0;
                        n_emit      = 1'b1;
                        n_state     = ST_SWEEP;
                    end else if (i_in.row_is_null) begin
                        n_res.null_row       = 1'b1;
                        n_res.distinct_count = r_next_code;
                        n_state              = ST_FINISH;
                    end else begin
                        n_key     = key_now;
                        n_ts      = ts_now;
                        mod_start = 1'b1;
                        n_state   = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    n_pos   = mod_rem[AW-1:0];
                    n_steps = '0;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                tbl_re  = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!tbl_rdata.used) begin
                    // Empty slot: claim it with the next dense code.
                    tbl_we               = 1'b1;
                    n_res.code           = r_next_code[CODE_W-1:0];
                    n_res.new_entry      = 1'b1;
                    n_res.dict_word      = r_key & byte_mask(r_stored_bytes);
                    n_next_code          = r_next_code + COUNT_W'(1);
                    n_res.distinct_count = r_next_code + COUNT_W'(1);
                    n_state              = ST_FINISH;
                end else if (tbl_rdata.key == r_key) begin
                    n_res.code           = tbl_rdata.code;
                    n_res.distinct_count = r_next_code;
                    n_state              = ST_FINISH;
                end else if (r_steps + SW'(1) == r_ts) begin
                    n_res.overflow       = 1'b1;
                    n_res.distinct_count = r_next_code;
                    n_state              = ST_FINISH;
                end else begin
                    n_steps = r_steps + SW'(1);
                    n_pos   = (pos_inc == r_ts) ? '0 : pos_inc[AW-1:0];
                    n_state = ST_READ;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_emit      = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_next_code <= '0;
            r_clr_addr  <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_code <= n_next_code;
            r_clr_addr  <= n_clr_addr;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
        r_ts    <= n_ts;
        r_steps <= n_steps;
        r_pos   <= n_pos;
        r_key   <= n_key;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.code           = r_out.code;
    assign o_out.null_row       = r_out.null_row;
    assign o_out.new_entry      = r_out.new_entry;
    assign o_out.dict_word      = r_out.dict_word;
    assign o_out.distinct_count = r_out.distinct_count;
    assign o_out.overflow       = r_out.overflow;

    // A new entry is never also a null row or an overflow.
    `DEP_ASSERT_NOW(a_new_excl, o_out.valid && o_out.new_entry, !o_out.overflow && !o_out.null_row, "new entry flagged together with null or overflow")
    // Claiming an empty slot advances the code counter by exactly one.
    `DEP_ASSERT_NEXT(a_code_step, r_state == ST_CHECK && !tbl_rdata.used, r_next_code == COUNT_W'($past(r_next_code) + COUNT_W'(1)), "code counter did not advance on new entry")
    // Every probe address stays inside the table size in use.
    `DEP_ASSERT_NOW(a_pos_range, r_state == ST_READ, SW'(r_pos) < r_ts && r_steps < r_ts, "probe outside the table or past one lap")
    // A finished result that the consumer has not taken is held.
    `DEP_ASSERT_NEXT(a_out_hold, r_out_valid && !o_out.ready, r_out_valid && $stable(r_out), "pending result changed before it was taken")

endmodule

/* src/dep_mod_unit.sv */
// Bit-serial remainder unit: 64-bit dividend modulo a narrow divisor, one bit per cycle.
// Depends on dep_pkg for the value width.
module dep_mod_unit #(
    parameter int SW = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dep_pkg::VALUE_W-1:0] i_dividend,
    input  logic [SW-1:0]               i_divisor,
    output logic                        o_done,
    output logic [SW-1:0]               o_rem
);
    import dep_pkg::*;

    localparam int CW = $clog2(VALUE_W);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [VALUE_W-1:0] r_div, n_div;
    logic [SW-1:0]      r_dvs, n_dvs;
    logic [SW-1:0]      r_rem, n_rem;
    logic [SW:0]        shifted;

    always_comb begin
        shifted = {r_rem, r_div[VALUE_W-1]};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_div   = r_div;
        n_dvs   = r_dvs;
        n_rem   = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_div  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_div = {r_div[VALUE_W-2:0], 1'b0};
            if (shifted >= {1'b0, r_dvs}) begin
                n_rem = SW'(shifted - {1'b0, r_dvs});
            end else begin
                n_rem = shifted[SW-1:0];
            end
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(VALUE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_div <= n_div;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* src/dep_table.sv */
// Hash slot memory: one write port, one read port with registered read data.
// Depends on dep_pkg for the slot record type.
module dep_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  dep_pkg::t_slot  i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output dep_pkg::t_slot  o_rdata
);
    import dep_pkg::*;

    t_slot mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the dictionary encoder with linear probing.
// Depends on dep_pkg, the dep_if interfaces and the dictionary_encoder_linear_probe RTL.
module tb_top;
    import dep_pkg::*;

    // The idle watchdog must outlast a full clear sweep, a full probe lap of the
    // largest table and the long consumer hold-off, with a wide margin.
    localparam int IDLE_LIMIT  = 20000;
    localparam int RANDOM_ROWS = 1950;
    localparam int HOLD_CYCLES = 600;
    localparam int DEPTH       = 1024;

    typedef enum int {K_ROW, K_CFG} row_kind_e;

    typedef struct {
        row_kind_e         kind;
        logic              op;
        logic [63:0]       val;
        logic              nul;
        logic              typed;
        t_result           res;
        logic [CFG_AW-1:0] addr;
        logic [CFG_DW-1:0] data;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    dep_in_if  in_if();
    dep_out_if out_if();
    dep_cfg_if cfg_if();

    dictionary_encoder_linear_probe DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the hash table and the registers, updated on every accepted
    // transaction exactly as the block is meant to update its own.
    logic               shadow_used [DEPTH];
    logic [63:0]        shadow_key  [DEPTH];
    logic [10:0]        shadow_code [DEPTH];
    logic [10:0]        shadow_next;
    logic [10:0]        shadow_tsize;
    logic [3:0]         shadow_vbytes;
    logic [3:0]         shadow_sbytes;

    t_result pending_results [$];

    // Typed expectation that travels with the row currently offered.
    logic    row_typed;
    t_result row_result;

    int errors;
    int rows_seen;
    int fresh_seen;
    int overflow_seen;
    int null_seen;
    int clear_seen;
    int idle_cycles;
    bit hold_now;

    function automatic logic [63:0] low_bytes_mask(input logic [3:0] nbytes);
        int n;
        n = (nbytes == 0) ? 1 : int'(nbytes);
        if (n >= 8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic int slots_active(input logic [10:0] raw);
        if (raw == 0) return 1;
        if (raw > DEPTH) return DEPTH;
        return int'(raw);
    endfunction

    // Encodes one row against the shadow table and returns the result it yields.
    function automatic t_result encode_row(input logic op, input logic [63:0] raw,
                                           input logic nul);
        t_result r;
        logic [63:0] v;
        int ts;
        int pos;
        bit hit;
        r   = '0;
        hit = 0;
        if (op == OP_CLEAR) begin
            for (int i = 0; i < DEPTH; i++) shadow_used[i] = 1'b0;
            shadow_next = '0;
            return r;
        end
        if (nul) begin
            r.null_row = 1'b1;
        end else begin
            v   = raw & low_bytes_mask(shadow_vbytes);
            ts  = slots_active(shadow_tsize);
            pos = int'(v % 64'(ts));
            for (int s = 0; s < ts && !hit; s++) begin
                if (!shadow_used[pos]) begin
                    shadow_used[pos] = 1'b1;
                    shadow_key[pos]  = v;
                    shadow_code[pos] = shadow_next;
                    r.code      = shadow_next[CODE_W-1:0];
                    r.new_entry = 1'b1;
                    r.dict_word = v & low_bytes_mask(shadow_sbytes);
                    shadow_next = shadow_next + 11'd1;
                    hit = 1;
                end else if (shadow_key[pos] == v) begin
                    r.code = shadow_code[pos][CODE_W-1:0];
                    hit = 1;
                end else begin
                    pos = (pos + 1 >= ts) ? 0 : pos + 1;
                end
            end
            r.overflow = !hit;
        end
        r.distinct_count = shadow_next;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // All monitoring happens on the clock edge, reading the values that were
    // settled before the edge, so the order of processes within a step is moot.
    always @(posedge i_clk) begin
        t_result p;
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.addr)
                    REG_TABLE_SIZE:   shadow_tsize  = cfg_if.data[10:0];
                    REG_VALUE_BYTES:  shadow_vbytes = cfg_if.data[3:0];
                    REG_STORED_BYTES: shadow_sbytes = cfg_if.data[3:0];
                    default: ;
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                p = encode_row(in_if.op, in_if.row_value, in_if.row_is_null);
                pending_results.push_back(row_typed ? row_result : p);
            end
            if (out_if.valid && out_if.ready) begin
                got = '{code: out_if.code, null_row: out_if.null_row,
                        new_entry: out_if.new_entry, dict_word: out_if.dict_word,
                        distinct_count: out_if.distinct_count, overflow: out_if.overflow};
                if (pending_results.size() == 0) begin
                    $error("result transaction arrived with nothing expected");
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    rows_seen++;
                    fresh_seen    += want.new_entry;
                    overflow_seen += want.overflow;
                    null_seen     += want.null_row;
                    if (want.code != got.code) begin
                        $error("code: expected %0d, got %0d", want.code, got.code);
                        errors++;
                    end
                    if (want.null_row != got.null_row) begin
                        $error("null_row: expected %0d, got %0d", want.null_row, got.null_row);
                        errors++;
                    end
                    if (want.new_entry != got.new_entry) begin
                        $error("new_entry: expected %0d, got %0d",
                               want.new_entry, got.new_entry);
                        errors++;
                    end
                    if (want.dict_word != got.dict_word) begin
                        $error("dict_word: expected %h, got %h", want.dict_word, got.dict_word);
                        errors++;
                    end
                    if (want.distinct_count != got.distinct_count) begin
                        $error("distinct_count: expected %0d, got %0d",
                               want.distinct_count, got.distinct_count);
                        errors++;
                    end
                    if (want.overflow != got.overflow) begin
                        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: any transaction on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Consumer side. It alternates stretches of full throughput with stretches of
    // random stalls, and once takes a long hold-off so the block backs up onto its
    // input. Exactly one assignment to ready per clock edge.
    initial begin
        int mode;
        int len;
        out_if.ready = 1'b0;
        forever begin
            if (hold_now) begin
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                    out_if.ready <= 1'b0;
                end
                hold_now = 0;
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(1, 40);
                repeat (len) begin
                    @(posedge i_clk);
                    out_if.ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) != 0);
                end
            end
        end
    end

    // Offers one row and leaves valid high once it is taken; the caller decides
    // whether the next row follows at once or after a gap.
    task automatic offer_row(input logic op, input logic [63:0] val, input logic nul,
                             input logic typed, input t_result res);
        in_if.valid       <= 1'b1;
        in_if.op          <= op;
        in_if.row_value   <= val;
        in_if.row_is_null <= nul;
        row_typed         <= typed;
        row_result        <= res;
        do @(posedge i_clk); while (!in_if.ready);
        if (op == OP_CLEAR) clear_seen++;
    endtask

    // Lowers valid and waits until every expected result has come back.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= addr;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    stim_row_t directed [30];

    initial begin
        int burst;
        int sent;
        int cur_ts;
        int n_rows;
        int pick;
        logic [3:0]  vb;
        logic [3:0]  sb;
        logic [10:0] ts_raw;
        logic [63:0] val;
        logic [63:0] m;
        bit held;

        errors = 0; rows_seen = 0; fresh_seen = 0; overflow_seen = 0;
        null_seen = 0; clear_seen = 0; idle_cycles = 0; hold_now = 0; held = 0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0; in_if.op = OP_ENCODE; in_if.row_value = '0;
        in_if.row_is_null = 1'b0;
        cfg_if.valid = 1'b0; cfg_if.addr = REG_TABLE_SIZE; cfg_if.data = '0;
        row_typed = 1'b0; row_result = '0;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_used[i] = 1'b0; shadow_key[i] = '0; shadow_code[i] = '0;
        end
        shadow_next = '0; shadow_tsize = 11'd1024; shadow_vbytes = 4'd8; shadow_sbytes = 4'd8;

        // Directed rows. Typed expectations are those obvious from the table
        // layout: slot 0 collisions, a lap overflow on a two-slot table, clears.
        directed = '{
            '{K_ROW, OP_ENCODE, 64'd0, 1'b0, 1'b1, '{10'd0, 1'b0, 1'b1, 64'd0, 11'd1, 1'b0}, 0, 0},
            '{K_ROW, OP_ENCODE, '1, 1'b0, 1'b1, '{10'd1, 1'b0, 1'b1, '1, 11'd2, 1'b0}, 0, 0},
            '{K_ROW, OP_ENCODE, 64'd0, 1'b0, 1'b1, '{10'd0, 1'b0, 1'b0, 64'd0, 11'd2, 1'b0}, 0, 0},
            '{K_ROW, OP_ENCODE, '1, 1'b1, 1'b1, '{10'd0, 1'b1, 1'b0, 64'd0, 11'd2, 1'b0}, 0, 0},
            '{K_ROW, OP_CLEAR, '1, 1'b1, 1'b1, '0, 0, 0},
            '{K_ROW, OP_ENCODE, 64'd1024, 1'b0, 1'b1,
              '{10'd0, 1'b0, 1'b1, 64'd1024, 11'd1, 1'b0}, 0, 0},
            '{K_ROW, OP_ENCODE, 64'd0, 1'b0, 1'b1, '{10'd1, 1'b0, 1'b1, 64'd0, 11'd2, 1'b0}, 0, 0},
            '{K_ROW, OP_ENCODE, 64'd2048, 1'b0, 1'b1,
              '{10'd2, 1'b0, 1'b1, 64'd2048, 11'd3, 1'b0}, 0, 0},
            '{K_ROW, OP_ENCODE, 64'd0, 1'b0, 1'b1, '{10'd1, 1'b0, 1'b0, 64'd0, 11'd3, 1'b0}, 0, 0},
            '{K_ROW, OP_ENCODE, 64'h8000_0000_0000_0000, 1'b0, 1'b0, '0, 0, 0},
            '{K_CFG, OP_ENCODE, 0, 0, 0, '0, REG_VALUE_BYTES, 11'd1},
            '{K_ROW, OP_ENCODE, 64'h1234_5600, 1'b0, 1'b1,
              '{10'd1, 1'b0, 1'b0, 64'd0, 11'd4, 1'b0}, 0, 0},
            '{K_ROW, OP_ENCODE, 64'hABCD_EF12_3456_7801, 1'b0, 1'b1,
              '{10'd4, 1'b0, 1'b1, 64'd1, 11'd5, 1'b0}, 0, 0},
            '{K_CFG, OP_ENCODE, 0, 0, 0, '0, REG_STORED_BYTES, 11'd2},
            '{K_CFG, OP_ENCODE, 0, 0, 0, '0, REG_VALUE_BYTES, 11'd8},
            '{K_ROW, OP_ENCODE, 64'h1122_3344_5566_7788, 1'b0, 1'b0, '0, 0, 0},
            '{K_CFG, OP_ENCODE, 0, 0, 0, '0, REG_TABLE_SIZE, 11'd2},
            '{K_ROW, OP_CLEAR, 64'd0, 1'b0, 1'b1, '0, 0, 0},
            '{K_ROW, OP_ENCODE, 64'd5, 1'b0, 1'b1, '{10'd0, 1'b0, 1'b1, 64'd5, 11'd1, 1'b0}, 0, 0},
            '{K_ROW, OP_ENCODE, 64'd6, 1'b0, 1'b1, '{10'd1, 1'b0, 1'b1, 64'd6, 11'd2, 1'b0}, 0, 0},
            '{K_ROW, OP_ENCODE, 64'd7, 1'b0, 1'b1, '{10'd0, 1'b0, 1'b0, 64'd0, 11'd2, 1'b1}, 0, 0},
            '{K_ROW, OP_ENCODE, 64'd5, 1'b0, 1'b1, '{10'd0, 1'b0, 1'b0, 64'd0, 11'd2, 1'b0}, 0, 0},
            '{K_CFG, OP_ENCODE, 0, 0, 0, '0, REG_TABLE_SIZE, 11'd0},
            '{K_ROW, OP_ENCODE, 64'd9, 1'b0, 1'b0, '0, 0, 0},
            '{K_CFG, OP_ENCODE, 0, 0, 0, '0, REG_TABLE_SIZE, 11'd2047},
            '{K_CFG, OP_ENCODE, 0, 0, 0, '0, REG_VALUE_BYTES, 11'd0},
            '{K_CFG, OP_ENCODE, 0, 0, 0, '0, REG_STORED_BYTES, 11'd15},
            '{K_ROW, OP_ENCODE, 64'hFFFF_FF07, 1'b0, 1'b0, '0, 0, 0},
            '{K_CFG, OP_ENCODE, 0, 0, 0, '0, REG_VALUE_BYTES, 11'd9},
            '{K_ROW, OP_ENCODE, '1, 1'b0, 1'b0, '0, 0, 0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].kind == K_CFG) begin
                drain_results();
                write_reg(directed[i].addr, directed[i].data);
            end else begin
                offer_row(directed[i].op, directed[i].val, directed[i].nul,
                          directed[i].typed, directed[i].res);
            end
        end

        // Random phases: each picks a register setting, mostly small tables so
        // that collisions, wraps and overflow laps are common, then streams rows
        // whose values mostly come from a small range with garbage above the
        // significant bytes.
        sent  = 0;
        burst = $urandom_range(1, 30);
        while (sent < RANDOM_ROWS) begin
            drain_results();
            pick = $urandom_range(0, 9);
            case (pick)
                0:       ts_raw = 11'd0;
                1:       ts_raw = ($urandom_range(0, 1) != 0) ? 11'd2047 : 11'd1024;
                8:       ts_raw = 11'($urandom_range(49, 300));
                9:       ts_raw = 11'd1024;
                default: ts_raw = 11'($urandom_range(1, 48));
            endcase
            vb = ($urandom_range(0, 1) != 0) ? 4'd8 : 4'($urandom_range(0, 15));
            sb = ($urandom_range(0, 1) != 0) ? 4'd8 : 4'($urandom_range(0, 15));
            write_reg(REG_TABLE_SIZE, ts_raw);
            write_reg(REG_VALUE_BYTES, 11'(vb));
            write_reg(REG_STORED_BYTES, 11'(sb));
            cur_ts = slots_active(ts_raw);
            m      = low_bytes_mask(vb);
            if ($urandom_range(0, 2) == 0) begin
                offer_row(OP_CLEAR, {$urandom, $urandom}, 1'($urandom), 1'b0, '0);
                sent++;
            end
            n_rows = $urandom_range(20, 80);
            repeat (n_rows) begin
                if (sent >= 600 && !held) begin
                    hold_now = 1;
                    held     = 1;
                end
                pick = $urandom_range(0, 99);
                val  = {$urandom, $urandom};
                if ($urandom_range(0, 9) < 7)
                    val = (val & ~m) | (64'($urandom_range(0, 3 * cur_ts + 3)) & m);
                if (pick < 2)
                    offer_row(OP_CLEAR, val, 1'($urandom), 1'b0, '0);
                else
                    offer_row(OP_ENCODE, val, pick < 12, 1'b0, '0);
                sent++;
                burst--;
                if (burst == 0) begin
                    burst = $urandom_range(1, 30);
                    if ($urandom_range(0, 3) != 0) begin
                        in_if.valid <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge i_clk);
                    end
                end
            end
        end

        drain_results();
        repeat (100) @(posedge i_clk);

        $display("covered %0d rows: %0d new entries, %0d overflow laps, %0d null rows",
                 rows_seen, fresh_seen, overflow_seen, null_seen);
        $display("%0d clears across random table sizes and byte widths, %0d mismatches",
                 clear_seen, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
